[sv/usr_pkg.sv]
// Package with the shared types, widths and constants of the ultrasonic ranger echo model.
`default_nettype none
package usr_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int DISTANCE_WIDTH = 14;

    localparam int TRIG_W  = 6;
    localparam int DELAY_W = 10;
    localparam int ECHO_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [TRIG_W-1:0] WIDTH_MAX = {TRIG_W{1'b1}};

    // The echo length is floor((250 * d + 21) / 43), done by a reciprocal multiply.
    localparam int Y_W          = DISTANCE_WIDTH + 8;
    localparam int Q_W          = DISTANCE_WIDTH + 3;
    localparam int RECIP_SHIFT  = DISTANCE_WIDTH + 14;
    localparam int RECIP_W      = DISTANCE_WIDTH + 9;
    localparam int PROD_W       = Y_W + RECIP_W;
    localparam longint RECIP_VALUE = ((64'd1 << RECIP_SHIFT) / 43) + 1;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_VALUE);
    localparam logic [Y_W-1:0] ROUND_TERM = Y_W'(21);

    localparam int CLAMP_W = (Q_W > ECHO_W) ? Q_W : ECHO_W;
    localparam int SAT_W   = (CLAMP_W > COUNT_WIDTH) ? CLAMP_W : COUNT_WIDTH;
    localparam logic [SAT_W-1:0] COUNT_MAX = SAT_W'((64'd1 << COUNT_WIDTH) - 1);

    localparam logic [TRIG_W-1:0]  MIN_TRIG_RST   = TRIG_W'(10);
    localparam logic [DELAY_W-1:0] ECHO_DELAY_RST = DELAY_W'(200);
    localparam logic [ECHO_W-1:0]  MIN_ECHO_RST   = ECHO_W'(116);
    localparam logic [ECHO_W-1:0]  MAX_ECHO_RST   = ECHO_W'(38000);

    localparam logic [IDX_W-1:0] CFG_MIN_TRIG   = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_ECHO_DELAY = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_MIN_ECHO   = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_MAX_ECHO   = IDX_W'(3);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_ECHO  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TRIG_W-1:0]  min_trigger_us;
        logic [DELAY_W-1:0] echo_delay_us;
        logic [ECHO_W-1:0]  min_echo_us;
        logic [ECHO_W-1:0]  max_echo_us;
    } t_cfg;

    typedef struct packed {
        logic           trig;
        logic [Q_W-1:0] quot;
    } t_calc;

endpackage
`default_nettype wire

[sv/ultrasonic_ranger_echo_model.sv]
// Top level of the ultrasonic ranger echo model: handshakes, configuration and pipeline control.
// Pipeline: three register stages; a request's result moves through them in order and is held
// in place while a later stage is stalled.
// Throughput: one request per cycle when the output is not stalled; the distance scaling, the
// reciprocal multiply and the phase update each take one register stage, so nothing iterates.
// Reset: synchronous and active low; it empties the pipeline, idles the phase machine and
// loads the configuration registers with their default values.
`default_nettype none
module ultrasonic_ranger_echo_model
    import usr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_trig_level,
    input  wire logic [DISTANCE_WIDTH-1:0] i_distance_mm,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_echo_level,
    output logic                           o_busy_res,
    input  wire logic                      i_cfg_we,
    input  wire logic [IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]          i_cfg_data
);

    logic  r_v1;
    logic  r_v2;
    logic  r_v3;
    logic  w_rdy1;
    logic  w_rdy2;
    logic  w_rdy3;
    logic  w_en1;
    logic  w_en2;
    logic  w_en3;
    t_cfg  r_cfg;
    t_calc w_calc;

    assign w_rdy3 = !r_v3 || !i_out_stall;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_en1  = i_in_valid && w_rdy1;
    assign w_en2  = r_v1 && w_rdy2;
    assign w_en3  = r_v2 && w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_trigger_us <= MIN_TRIG_RST;
            r_cfg.echo_delay_us  <= ECHO_DELAY_RST;
            r_cfg.min_echo_us    <= MIN_ECHO_RST;
            r_cfg.max_echo_us    <= MAX_ECHO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_TRIG:   r_cfg.min_trigger_us <= i_cfg_data[TRIG_W-1:0];
                CFG_ECHO_DELAY: r_cfg.echo_delay_us  <= i_cfg_data[DELAY_W-1:0];
                CFG_MIN_ECHO:   r_cfg.min_echo_us    <= i_cfg_data[ECHO_W-1:0];
                CFG_MAX_ECHO:   r_cfg.max_echo_us    <= i_cfg_data[ECHO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    usr_range_calc u_calc (
        .i_clk         (i_clk),
        .i_en1         (w_en1),
        .i_en2         (w_en2),
        .i_trig_level  (i_trig_level),
        .i_distance_mm (i_distance_mm),
        .o_calc        (w_calc)
    );

    usr_phase_ctrl u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en3),
        .i_calc       (w_calc),
        .i_cfg        (r_cfg),
        .o_echo_level (o_echo_level),
        .o_busy_res   (o_busy_res)
    );

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_v3;

endmodule
`default_nettype wire

[sv/usr_range_calc.sv]
// Two pipeline stages that turn the distance of each request into a raw echo length.
`default_nettype none
module usr_range_calc
    import usr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_en1,
    input  wire logic                      i_en2,
    input  wire logic                      i_trig_level,
    input  wire logic [DISTANCE_WIDTH-1:0] i_distance_mm,
    output t_calc                          o_calc
);

    logic [Y_W-1:0]    w_y;
    logic [PROD_W-1:0] w_prod;
    logic [Y_W-1:0]    r_y;
    logic              r_trig1;
    t_calc             r_calc;

    assign w_y = (Y_W'(i_distance_mm) << 8) - (Y_W'(i_distance_mm) << 2)
               - (Y_W'(i_distance_mm) << 1) + ROUND_TERM;

    assign w_prod = PROD_W'(r_y) * PROD_W'(RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_y     <= w_y;
            r_trig1 <= i_trig_level;
        end
        if (i_en2) begin
            r_calc.trig <= r_trig1;
            r_calc.quot <= w_prod[RECIP_SHIFT +: Q_W];
        end
    end

    assign o_calc = r_calc;

endmodule
`default_nettype wire

[sv/usr_phase_ctrl.sv]
// Trigger pulse measurement, echo phase machine and the result register.
`default_nettype none
module usr_phase_ctrl
    import usr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_calc i_calc,
    input  wire t_cfg  i_cfg,
    output logic       o_echo_level,
    output logic       o_busy_res
);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [COUNT_WIDTH-1:0] r_phase_count;
    logic [COUNT_WIDTH-1:0] n_phase_count;
    logic [COUNT_WIDTH-1:0] r_echo_len;
    logic [COUNT_WIDTH-1:0] n_echo_len;
    logic                   r_prev;
    logic                   n_prev;
    logic [TRIG_W-1:0]      r_width;
    logic [TRIG_W-1:0]      n_width;
    logic                   r_echo;
    logic                   n_echo;
    logic                   r_busy;
    logic                   n_busy;
    logic [CLAMP_W-1:0]     w_clamp;
    logic [SAT_W-1:0]       w_sat;
    logic [COUNT_WIDTH-1:0] w_len;

    always_comb begin
        if (CLAMP_W'(i_calc.quot) < CLAMP_W'(i_cfg.min_echo_us)) begin
            w_clamp = CLAMP_W'(i_cfg.min_echo_us);
        end else if (CLAMP_W'(i_calc.quot) > CLAMP_W'(i_cfg.max_echo_us)) begin
            w_clamp = CLAMP_W'(i_cfg.max_echo_us);
        end else begin
            w_clamp = CLAMP_W'(i_calc.quot);
        end
        w_sat = SAT_W'(w_clamp);
        if (w_sat > COUNT_MAX) begin
            w_sat = COUNT_MAX;
        end
        w_len = COUNT_WIDTH'(w_sat);
    end

    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_echo_len    = r_echo_len;
        n_width       = r_width;
        n_prev        = i_calc.trig;
        case (r_phase)
            PH_DELAY: begin
                if (r_phase_count <= COUNT_WIDTH'(1)) begin
                    if (r_echo_len == '0) begin
                        n_phase       = PH_IDLE;
                        n_phase_count = '0;
                    end else begin
                        n_phase       = PH_ECHO;
                        n_phase_count = r_echo_len;
                    end
                end else begin
                    n_phase_count = r_phase_count - COUNT_WIDTH'(1);
                end
            end
            PH_ECHO: begin
                if (r_phase_count <= COUNT_WIDTH'(1)) begin
                    n_phase       = PH_IDLE;
                    n_phase_count = '0;
                end else begin
                    n_phase_count = r_phase_count - COUNT_WIDTH'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (i_calc.trig && !r_prev) begin
            n_width = TRIG_W'(1);
        end else if (i_calc.trig && r_prev) begin
            if (r_width < WIDTH_MAX) begin
                n_width = r_width + TRIG_W'(1);
            end
        end else if (!i_calc.trig && r_prev) begin
            if (r_width >= i_cfg.min_trigger_us && r_phase == PH_IDLE) begin
                n_echo_len    = w_len;
                n_phase       = PH_DELAY;
                n_phase_count = COUNT_WIDTH'(i_cfg.echo_delay_us);
            end
            n_width = '0;
        end
    end

    always_comb begin
        n_echo = (n_phase == PH_ECHO);
        n_busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_count <= '0;
            r_echo_len    <= '0;
            r_prev        <= 1'b0;
            r_width       <= '0;
            r_echo        <= 1'b0;
            r_busy        <= 1'b0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_echo_len    <= n_echo_len;
            r_prev        <= n_prev;
            r_width       <= n_width;
            r_echo        <= n_echo;
            r_busy        <= n_busy;
        end
    end

    assign o_echo_level = r_echo;
    assign o_busy_res   = r_busy;

    a_echo_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_echo |-> r_busy)
        else $error("echo high without busy");

    a_echo_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ECHO) |-> (r_phase_count != '0))
        else $error("echo phase with empty count");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_phase_count == '0))
        else $error("idle phase with pending count");

    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_phase != PH_IDLE))
        else $error("busy output while phase machine is idle");

endmodule
`default_nettype wire

[dv/ranger_echo_checker.sv]
`timescale 1ns / 1ps
// Checker for the ultrasonic ranger: tracks the tick stream, predicts echo and busy, compares results.
module ranger_echo_checker
    import usr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic                      i_trig_level,
    input  wire logic [DISTANCE_WIDTH-1:0] i_distance_mm,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic                      i_echo_level,
    input  wire logic                      i_busy_res,
    input  wire logic                      i_cfg_we,
    input  wire logic [IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_W-1:0]          i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output logic                           o_ranging
);

    localparam longint unsigned SPAN_SAT = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [TRIG_W-1:0] WIDTH_SAT = {TRIG_W{1'b1}};

    typedef struct packed {
        logic echo_level;
        logic busy_res;
    } t_pin_levels;

    t_cfg                   ranger_cfg;
    logic                   trig_seen;
    logic [TRIG_W-1:0]      pulse_width;
    t_phase                 phase_q;
    logic [COUNT_WIDTH-1:0] phase_left;
    logic [ECHO_W-1:0]      echo_span_q;
    t_pin_levels            levels_due[$];
    int                     mismatches = 0;

    function automatic logic [ECHO_W-1:0] echo_span(input logic [DISTANCE_WIDTH-1:0] dist_mm);
        longint unsigned span;
        span = (64'(dist_mm) * 64'd2000 + 64'd172) / 64'd344;
        if (span < 64'(ranger_cfg.min_echo_us)) begin
            span = 64'(ranger_cfg.min_echo_us);
        end else if (span > 64'(ranger_cfg.max_echo_us)) begin
            span = 64'(ranger_cfg.max_echo_us);
        end
        if (span > SPAN_SAT) begin
            span = SPAN_SAT;
        end
        return ECHO_W'(span);
    endfunction

    // The phase machine moves first; a trigger fall only starts a measurement from idle.
    function automatic t_pin_levels tick_ranger(input logic trig,
                                                input logic [DISTANCE_WIDTH-1:0] dist_mm);
        logic        was_idle;
        t_pin_levels levels;
        was_idle = (phase_q != PH_DELAY) && (phase_q != PH_ECHO);
        case (phase_q)
            PH_DELAY: begin
                if (phase_left < 2) begin
                    if (echo_span_q == '0) begin
                        phase_q    = PH_IDLE;
                        phase_left = '0;
                    end else begin
                        phase_q    = PH_ECHO;
                        phase_left = COUNT_WIDTH'(echo_span_q);
                    end
                end else begin
                    phase_left--;
                end
            end
            PH_ECHO: begin
                if (phase_left < 2) begin
                    phase_q    = PH_IDLE;
                    phase_left = '0;
                end else begin
                    phase_left--;
                end
            end
            default: begin
                phase_q = PH_IDLE;
            end
        endcase
        if (trig && !trig_seen) begin
            pulse_width = TRIG_W'(1);
        end else if (trig && trig_seen) begin
            if (pulse_width != WIDTH_SAT) begin
                pulse_width++;
            end
        end else if (!trig && trig_seen) begin
            if (pulse_width >= ranger_cfg.min_trigger_us && was_idle) begin
                echo_span_q = echo_span(dist_mm);
                phase_q     = PH_DELAY;
                phase_left  = COUNT_WIDTH'(ranger_cfg.echo_delay_us);
            end
            pulse_width = '0;
        end
        trig_seen = trig;
        levels.echo_level = (phase_q == PH_ECHO);
        levels.busy_res   = (phase_q != PH_IDLE);
        return levels;
    endfunction

    function automatic void compare_pin(input string field, input logic due, input logic seen);
        if (seen !== due) begin
            mismatches++;
            $error("%s mismatch: expected %0b, actual %0b", field, due, seen);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pin_levels due;
        if (!i_rst_n) begin
            ranger_cfg  = '{MIN_TRIG_RST, ECHO_DELAY_RST, MIN_ECHO_RST, MAX_ECHO_RST};
            trig_seen   = 1'b0;
            pulse_width = '0;
            phase_q     = PH_IDLE;
            phase_left  = '0;
            echo_span_q = '0;
            levels_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (levels_due.size() == 0) begin
                    mismatches++;
                    $error("result with nothing due: echo_level=%0b busy_res=%0b",
                           i_echo_level, i_busy_res);
                end else begin
                    due = levels_due.pop_front();
                    compare_pin("echo_level", due.echo_level, i_echo_level);
                    compare_pin("busy_res", due.busy_res, i_busy_res);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_TRIG:   ranger_cfg.min_trigger_us = i_cfg_data[TRIG_W-1:0];
                    CFG_ECHO_DELAY: ranger_cfg.echo_delay_us  = i_cfg_data[DELAY_W-1:0];
                    CFG_MIN_ECHO:   ranger_cfg.min_echo_us    = i_cfg_data[ECHO_W-1:0];
                    CFG_MAX_ECHO:   ranger_cfg.max_echo_us    = i_cfg_data[ECHO_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                levels_due.push_back(tick_ranger(i_trig_level, i_distance_mm));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= levels_due.size();
        o_ranging    <= (phase_q != PH_IDLE);
    end

endmodule

[dv/tb_ultrasonic_ranger_echo_model.sv]
`timescale 1ns / 1ps
// Testbench top for the ultrasonic ranger echo model: clock, reset, tick stimulus and verdict.
module tb_ultrasonic_ranger_echo_model;
    import usr_pkg::*;

    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 400;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      trig_level = 1'b0;
    logic [DISTANCE_WIDTH-1:0] distance_mm = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      echo_level;
    logic                      busy_res;
    logic                      cfg_we = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;

    int   fail_count;
    int   pending;
    logic ranging;

    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int ticks_sent = 0;
    int cur_min_trig = 10;
    int dist_near = 0;
    int dist_wide_pct = 0;

    ultrasonic_ranger_echo_model dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_trig_level  (trig_level),
        .i_distance_mm (distance_mm),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_echo_level  (echo_level),
        .o_busy_res    (busy_res),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    ranger_echo_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_trig_level  (trig_level),
        .i_distance_mm (distance_mm),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_echo_level  (echo_level),
        .i_busy_res    (busy_res),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_ranging     (ranging)
    );

    always #1 clk = ~clk;

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [DISTANCE_WIDTH-1:0] pick_distance();
        if ($urandom_range(99) < dist_wide_pct) begin
            return DISTANCE_WIDTH'($urandom);
        end
        return DISTANCE_WIDTH'($urandom_range(dist_near));
    endfunction

    task automatic send_tick(input logic trig, input logic [DISTANCE_WIDTH-1:0] dist_mm);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        trig_level  <= trig;
        distance_mm <= dist_mm;
        do @(posedge clk); while (in_stall);
        ticks_sent++;
    endtask

    task automatic send_pulse(input int width, input logic [DISTANCE_WIDTH-1:0] fall_dist);
        repeat (width) send_tick(1'b1, pick_distance());
        send_tick(1'b0, fall_dist);
    endtask

    // The busy flag lags by one request, so two low ticks go out before it is trusted.
    task automatic settle();
        repeat (2) send_tick(1'b0, pick_distance());
        while (ranging) send_tick(1'b0, pick_distance());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_ranger(input int min_trig, input int delay,
                                  input int min_echo, input int max_echo);
        logic [IDX_W-1:0] reg_ids [4];
        int               reg_vals [4];
        reg_ids  = '{CFG_MIN_TRIG, CFG_ECHO_DELAY, CFG_MIN_ECHO, CFG_MAX_ECHO};
        reg_vals = '{min_trig, delay, min_echo, max_echo};
        settle();
        drain();
        foreach (reg_ids[k]) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_ids[k];
            cfg_data  <= CFG_W'(reg_vals[k]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_min_trig = min_trig;
    endtask

    task automatic random_phase(input int n_ticks);
        int stop_at;
        int lo;
        int width;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(0, 3)) send_tick(1'b0, pick_distance());
                if ($urandom_range(99) < 10) begin
                    width = $urandom_range(60, 70);
                end else begin
                    lo = (cur_min_trig > 3) ? cur_min_trig - 2 : 1;
                    width = $urandom_range(lo, cur_min_trig + 3);
                end
                send_pulse(width, pick_distance());
                if ($urandom_range(99) < 30) begin
                    repeat ($urandom_range(0, 8)) send_tick(1'b0, pick_distance());
                end else begin
                    settle();
                end
            end else begin
                repeat ($urandom_range(1, 12)) send_tick(1'($urandom), pick_distance());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dist_near = (1 << DISTANCE_WIDTH) - 1;
        send_pulse(9, '0);
        send_pulse(10, '0);

        // A trigger fall on the tick where the echo ends is ignored; the next one is taken.
        program_ranger(1, 2, 3, 3);
        send_pulse(1, '0);
        repeat (3) send_tick(1'b0, '0);
        send_pulse(1, '1);
        send_pulse(1, '1);
        random_phase(150);

        program_ranger(0, 0, 0, 65535);
        dist_near = 12;
        send_pulse(1, '0);
        settle();
        send_pulse(1, DISTANCE_WIDTH'(1));
        settle();
        random_phase(150);

        program_ranger(63, 150, 0, 0);
        dist_near = (1 << DISTANCE_WIDTH) - 1;
        random_phase(100);

        gaps_on = 1'b0;
        program_ranger(5, 7, 50, 20);
        dist_near = 20;
        dist_wide_pct = 40;
        random_phase(200);
        gaps_on = 1'b1;

        program_ranger(12, 15, 10, 40);
        dist_near = 9;
        dist_wide_pct = 10;
        random_phase(100);
        hold_req = 1'b1;
        random_phase(200);

        program_ranger(2, 3, 65535, 65535);
        send_pulse(2, '1);
        repeat (40) send_tick(1'b0, pick_distance());
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
